FILE: rtl/sckst_pkg.sv
// ----------------------------------------------------------------------------
// sckst_pkg
// Shared types and constants for the scan code key state tracker.
// ----------------------------------------------------------------------------
package sckst_pkg;

  // Table geometry
  localparam int unsigned KeyTableDepth = 256;
  localparam int unsigned KeyIdxW       = $clog2(KeyTableDepth);
  localparam int unsigned CodeW         = 8;

  // Scan code constants
  localparam logic [CodeW-1:0] PrefixCode = 8'hE0;
  localparam int unsigned      ReleaseBit = CodeW - 1;

  // Command codes
  typedef enum logic [1:0] {
    CmdScan  = 2'd0,
    CmdQuery = 2'd1,
    CmdClear = 2'd2
  } cmd_e;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]         cmd;
    logic [CodeW-1:0]   scan_code;
    logic [KeyIdxW-1:0] key_index;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic accepted;
    logic key_hit;
    logic key_pressed;
    logic key_released;
  } out_item_t;

endpackage

FILE: rtl/scan_code_key_state_tracker_top.sv
// ----------------------------------------------------------------------------
// scan_code_key_state_tracker_top
// Filters set-1 scan codes and keeps hit, pressed and released flags per key.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_ready_o | sckst_pkg::in_item_t
//   out     | output    | out_valid_o/out_ready_i | sckst_pkg::out_item_t
//
// One transaction per cycle while the output is not stalled; an accepted input
// is held in the input register, and its result then in the result register.
// All table and filter updates happen in the single pass out of the input
// register, so back-to-back transactions see each other's effects in order.
// Reset clears the filter state and all 256 key entries at once.
// A stalled output freezes the input register; in_ready_o drops only when
// both registers are full and the result is not being taken.
// ----------------------------------------------------------------------------
module scan_code_key_state_tracker_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sckst_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sckst_pkg::out_item_t out_item_o
);

  localparam int unsigned Depth = sckst_pkg::KeyTableDepth;
  localparam int unsigned IdxW  = sckst_pkg::KeyIdxW;
  localparam int unsigned CodeW = sckst_pkg::CodeW;

  // Input register
  logic                s1_valid_q;
  sckst_pkg::in_item_t s1_item_q;
  logic                s1_advance;

  // Result register
  logic                 out_valid_q;
  sckst_pkg::out_item_t out_item_q, out_item_d;

  // Filter state
  logic [CodeW-1:0] last_code_q, last_code_d;
  logic [CodeW-1:0] pf_code_q, pf_code_d;
  logic [CodeW-1:0] pf_last_q, pf_last_d;
  logic             ext_pending_q, ext_pending_d;

  // Key flag table, one bit per entry per flag
  logic [Depth-1:0] hit_q, hit_d;
  logic [Depth-1:0] pressed_q, pressed_d;
  logic [Depth-1:0] released_q, released_d;

  logic             do_update;
  logic [IdxW-1:0]  slot;
  logic [IdxW-1:0]  qidx;
  logic [CodeW-1:0] code;
  logic             pass;

  // Advance the pipe when the result register is free or being drained
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign do_update  = s1_valid_q && s1_advance;

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  assign code = s1_item_q.scan_code;
  assign qidx = s1_item_q.key_index;
  assign slot = {ext_pending_q, code[CodeW-2:0]};

  // Evaluate the filter, update the table, build the result
  always_comb begin
    last_code_d   = last_code_q;
    pf_code_d     = pf_code_q;
    pf_last_d     = pf_last_q;
    ext_pending_d = ext_pending_q;
    hit_d         = hit_q;
    pressed_d     = pressed_q;
    released_d    = released_q;
    out_item_d    = '0;
    pass          = 1'b0;

    case (sckst_pkg::cmd_e'(s1_item_q.cmd))
      sckst_pkg::CmdScan: begin
        if (last_code_q == sckst_pkg::PrefixCode) begin
          pf_code_d = code;
        end else if (code != sckst_pkg::PrefixCode) begin
          pf_code_d = '0;
        end
        pass = (code != last_code_q) &&
               ((pf_code_d != pf_last_q) || (pf_last_q == '0));
        last_code_d = code;
        pf_last_d   = pf_code_d;
        out_item_d.accepted = pass;
        if (pass) begin
          if (code == sckst_pkg::PrefixCode) begin
            ext_pending_d = 1'b1;
          end else begin
            if (code[sckst_pkg::ReleaseBit]) begin
              pressed_d[slot]  = 1'b0;
              released_d[slot] = 1'b1;
            end else begin
              hit_d[slot]     = 1'b1;
              pressed_d[slot] = 1'b1;
            end
            ext_pending_d = 1'b0;
          end
        end
      end
      sckst_pkg::CmdQuery: begin
        out_item_d.key_hit      = hit_q[qidx];
        out_item_d.key_pressed  = pressed_q[qidx];
        out_item_d.key_released = released_q[qidx];
      end
      sckst_pkg::CmdClear: begin
        hit_d      = '0;
        released_d = '0;
      end
      default: begin
        out_item_d = '0;
      end
    endcase
  end

  // Commit state for each transaction leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_code_q   <= '0;
      pf_code_q     <= '0;
      pf_last_q     <= '0;
      ext_pending_q <= 1'b0;
      hit_q         <= '0;
      pressed_q     <= '0;
      released_q    <= '0;
    end else if (do_update) begin
      last_code_q   <= last_code_d;
      pf_code_q     <= pf_code_d;
      pf_last_q     <= pf_last_d;
      ext_pending_q <= ext_pending_d;
      hit_q         <= hit_d;
      pressed_q     <= pressed_d;
      released_q    <= released_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: rtl/sckst_checker.sv
// ----------------------------------------------------------------------------
// sckst_checker
// Port-level checks for the scan code key state tracker, bound to the top.
// ----------------------------------------------------------------------------
module sckst_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input sckst_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input sckst_pkg::out_item_t out_item_o
);

  // A scan code result never carries query flags
  a_accept_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.accepted |->
      !(out_item_o.key_hit || out_item_o.key_pressed || out_item_o.key_released))
    else $error("accepted result carries key flags");

  // An empty result register always lets input in
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Hold a waiting input transaction unchanged until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input changed while waiting");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

endmodule

bind scan_code_key_state_tracker_top sckst_checker u_sckst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the scan code key state tracker. Drives scan codes, key
// queries, frame clears and unused commands through the valid/ready input
// channel, predicts each result in a scoreboard that mirrors the repeat
// filter and the key flag table, and checks every result in order. Both
// channels idle at random. The sender drains the block at least once.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Flag bit positions in a key entry
  localparam int unsigned FlagHit      = 0;
  localparam int unsigned FlagPressed  = 1;
  localparam int unsigned FlagReleased = 2;

  // Command code with no function
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int unsigned RandomItems = 800;

  // Tracks the key table and the repeat filter, and checks results in order
  class key_state_checker;
    logic [sckst_pkg::CodeW-1:0] last_code;
    logic [sckst_pkg::CodeW-1:0] follow_code;
    logic [sckst_pkg::CodeW-1:0] follow_last;
    logic                        ext_pending;
    logic [2:0]                  flags[sckst_pkg::KeyTableDepth];
    sckst_pkg::out_item_t        expected_q[$];
    int                          mismatches;

    function new();
      last_code   = '0;
      follow_code = '0;
      follow_last = '0;
      ext_pending = 1'b0;
      mismatches  = 0;
      foreach (flags[i]) flags[i] = '0;
    endfunction

    // Compute the result of one transaction and advance the table state
    function sckst_pkg::out_item_t predict_flags(sckst_pkg::in_item_t it);
      sckst_pkg::out_item_t          res;
      logic                          pass;
      logic [sckst_pkg::KeyIdxW-1:0] slot;
      logic [sckst_pkg::CodeW-1:0]   code;
      res  = '0;
      code = it.scan_code;
      case (it.cmd)
        sckst_pkg::CmdScan: begin
          // Repeat filter: plain repeats and repeats of the prefixed code
          if (last_code == sckst_pkg::PrefixCode) begin
            follow_code = code;
          end else if (code != sckst_pkg::PrefixCode) begin
            follow_code = '0;
          end
          pass = (code != last_code) &&
                 ((follow_code != follow_last) || (follow_last == '0));
          last_code   = code;
          follow_last = follow_code;
          if (pass) begin
            res.accepted = 1'b1;
            if (code == sckst_pkg::PrefixCode) begin
              ext_pending = 1'b1;
            end else begin
              slot = {ext_pending, code[sckst_pkg::ReleaseBit-1:0]};
              if (code[sckst_pkg::ReleaseBit]) begin
                flags[slot] = '0 | (flags[slot] & (3'b1 << FlagHit)) |
                              (3'b1 << FlagReleased);
              end else begin
                flags[slot] = flags[slot] | (3'b1 << FlagHit) | (3'b1 << FlagPressed);
              end
              ext_pending = 1'b0;
            end
          end
        end
        sckst_pkg::CmdQuery: begin
          res.key_hit      = flags[it.key_index][FlagHit];
          res.key_pressed  = flags[it.key_index][FlagPressed];
          res.key_released = flags[it.key_index][FlagReleased];
        end
        sckst_pkg::CmdClear: begin
          // Keep only the held-down state across frames
          foreach (flags[i]) flags[i] = flags[i] & (3'b1 << FlagPressed);
        end
        default: begin
        end
      endcase
      return res;
    endfunction

    function void note_item(sckst_pkg::in_item_t it);
      expected_q.push_back(predict_flags(it));
    endfunction

    function void check_flags(sckst_pkg::out_item_t got);
      sckst_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: %b", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        mismatches++;
      end
      if (got.key_hit !== want.key_hit) begin
        $error("key_hit: expected %0b, got %0b", want.key_hit, got.key_hit);
        mismatches++;
      end
      if (got.key_pressed !== want.key_pressed) begin
        $error("key_pressed: expected %0b, got %0b", want.key_pressed, got.key_pressed);
        mismatches++;
      end
      if (got.key_released !== want.key_released) begin
        $error("key_released: expected %0b, got %0b", want.key_released, got.key_released);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  sckst_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_ready;
  sckst_pkg::out_item_t out_item;

  key_state_checker sb;
  logic             idle_en;
  int               sent;
  logic [6:0]       key_pool[8];

  scan_code_key_state_tracker_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Gap length: mostly none or short, a few long
  function automatic int rand_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send(logic [1:0] cmd, logic [7:0] code, logic [7:0] idx);
    sckst_pkg::in_item_t it;
    int                  gap;
    it.cmd       = cmd;
    it.scan_code = code;
    it.key_index = idx;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    sent++;
  endtask

  // Hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Press or release one key, optionally prefixed and with typematic repeats, then maybe query it
  task automatic key_event();
    logic [6:0] key;
    logic       ext;
    logic       rel;
    int         reps;
    key  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                       : key_pool[$urandom_range(0, 7)];
    ext  = ($urandom_range(0, 2) == 0);
    rel  = 1'($urandom_range(0, 1));
    reps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    repeat (reps) begin
      if (ext) send(sckst_pkg::CmdScan, sckst_pkg::PrefixCode, rand_byte());
      send(sckst_pkg::CmdScan, {rel, key}, rand_byte());
    end
    if ($urandom_range(0, 1) == 1) send(sckst_pkg::CmdQuery, rand_byte(), {ext, key});
  endtask

  // Sink side: check results and stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_flags(out_item);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = rand_gap();
      end
    end
  end

  // Stimulus
  initial begin
    int start;
    int r;
    sb       = new();
    idle_en  = 1'b1;
    sent     = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Table after reset, lowest and highest entries
    send(sckst_pkg::CmdQuery, 8'h00, 8'h00);
    send(sckst_pkg::CmdQuery, 8'hFF, 8'hFF);
    // Press, plain repeat dropped, release, clear
    send(sckst_pkg::CmdScan, 8'h1E, 8'h00);
    send(sckst_pkg::CmdScan, 8'h1E, 8'hFF);
    send(sckst_pkg::CmdQuery, 8'h00, 8'h1E);
    send(sckst_pkg::CmdScan, 8'h9E, 8'h00);
    send(sckst_pkg::CmdQuery, 8'h00, 8'h1E);
    send(sckst_pkg::CmdClear, 8'h00, 8'h00);
    send(sckst_pkg::CmdQuery, 8'h00, 8'h1E);
    // Prefixed key, then the prefixed code repeated after a new prefix
    send(sckst_pkg::CmdScan, sckst_pkg::PrefixCode, 8'h00);
    send(sckst_pkg::CmdScan, 8'h48, 8'h00);
    send(sckst_pkg::CmdQuery, 8'h00, 8'hC8);
    send(sckst_pkg::CmdScan, sckst_pkg::PrefixCode, 8'h00);
    send(sckst_pkg::CmdScan, 8'h48, 8'h00);
    send(sckst_pkg::CmdScan, sckst_pkg::PrefixCode, 8'h00);
    send(sckst_pkg::CmdScan, 8'hC8, 8'h00);
    send(sckst_pkg::CmdQuery, 8'h00, 8'hC8);
    // Prefix repeated, code extremes, unused command
    send(sckst_pkg::CmdScan, sckst_pkg::PrefixCode, 8'h00);
    send(sckst_pkg::CmdScan, sckst_pkg::PrefixCode, 8'h00);
    send(sckst_pkg::CmdScan, 8'h00, 8'h00);
    send(sckst_pkg::CmdScan, 8'hFF, 8'h00);
    send(sckst_pkg::CmdScan, 8'h80, 8'h00);
    send(sckst_pkg::CmdScan, 8'h7F, 8'h00);
    send(sckst_pkg::CmdQuery, 8'h00, 8'hFF);
    send(CmdUnused, 8'hFF, 8'hFF);
    drain();

    foreach (key_pool[i]) key_pool[i] = 7'($urandom_range(1, 127));

    // Random part: mostly key sequences, some queries, clears and noise
    start = sent;
    while (sent - start < RandomItems) begin
      if ($urandom_range(0, 39) == 0) idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 149) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        key_event();
      end else if (r < 80) begin
        if ($urandom_range(0, 1) == 1) begin
          send(sckst_pkg::CmdQuery, rand_byte(), rand_byte());
        end else begin
          send(sckst_pkg::CmdQuery, rand_byte(), {1'($urandom_range(0, 1)),
                                                  key_pool[$urandom_range(0, 7)]});
        end
      end else if (r < 85) begin
        send(sckst_pkg::CmdClear, rand_byte(), rand_byte());
      end else begin
        send(2'($urandom_range(0, 3)), rand_byte(), rand_byte());
      end
    end

    // Wait out the remaining results, then report
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sckst_pkg.sv
rtl/scan_code_key_state_tracker_top.sv
rtl/sckst_checker.sv
sim/tb.sv
